/* sv/best_fit_interval_slot_reuse_top_defines.svh */
// assertion macros shared by the slot reuse block
// no dependencies
`ifndef BEST_FIT_INTERVAL_SLOT_REUSE_TOP_DEFINES_SVH
`define BEST_FIT_INTERVAL_SLOT_REUSE_TOP_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define BFI_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define BFI_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* sv/bfi_pkg.sv */
// types and constants of the slot reuse block
// no dependencies
package bfi_pkg;
    localparam int unsigned BYTES_W = 40;
    localparam int unsigned IDX_W = 16;
    localparam int unsigned OUT_IDX_W = 5;

    typedef struct packed {
        logic [15:0] dyn_sizes_ident;
        logic [15:0] type_ident;
        logic [39:0] byte_size;
        logic [3:0]  mem_space;
        logic [7:0]  elem_kind;
        logic [15:0] last_use_index;
        logic [15:0] def_index;
    } item_t;

    typedef struct packed {
        logic        table_full;
        logic [39:0] waste;
        logic        cast_needed;
        logic        reused;
        logic [4:0]  slot_index;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;
endpackage

/* sv/bfi_ram.sv */
// generic single-write ram with registered read
// no dependencies
module bfi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* sv/bfi_front.sv */
// front end: two-entry queue of accepted intervals
// depends on bfi_pkg
module bfi_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  bfi_pkg::item_t in_item,
    output logic          q_valid,
    input  logic          q_ready,
    output bfi_pkg::item_t q_item
);
    bfi_pkg::item_t buf_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       rd_reg, wr_reg;
    logic       push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = buf_reg[rd_reg];
    assign push = in_valid && in_ready;
    assign pop  = q_valid && q_ready;

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wr_reg <= ~wr_reg;
            end
            if (pop) begin
                rd_reg <= ~rd_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wr_reg] <= in_item;
        end
    end
endmodule

/* sv/bfi_back.sv */
// back end: slot scan, best-fit choice and table update
// depends on bfi_pkg, bfi_ram, defines header
`include "best_fit_interval_slot_reuse_top_defines.svh"
module bfi_back #(
    parameter int SLOT_COUNT = 32
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_valid,
    output logic            q_ready,
    input  bfi_pkg::item_t  q_item,
    output logic            m_valid,
    input  logic            m_ready,
    output bfi_pkg::result_t m_res
);
    localparam int AW = $clog2(SLOT_COUNT);
    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam int SW = 16 + 8 + 4 + 40 + 16 + 16;

    bfi_pkg::state_t state_reg, state_next;
    bfi_pkg::item_t  it_reg;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   scan_reg, scan_next;
    logic            rvalid_reg;
    logic            rdok_reg;
    logic [AW-1:0]   rslot_reg;
    logic            found_reg, stop_reg;
    logic [AW-1:0]   best_reg;
    logic [39:0]     bestw_reg;
    logic            bestcast_reg;
    logic            outv_reg;
    bfi_pkg::result_t res_reg;

    logic            we;
    logic [AW-1:0]   waddr;
    logic [SW-1:0]   wdata, rdata;
    logic [AW-1:0]   raddr;
    logic [15:0]     s_last, s_type, s_dyn;
    logic [7:0]      s_ek;
    logic [3:0]      s_ms;
    logic [39:0]     s_bytes, w;
    logic            fit, take, scan_end, accept;
    logic            fire;

    bfi_ram #(.WIDTH(SW), .DEPTH(SLOT_COUNT)) u_ram (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    assign {s_last, s_ek, s_ms, s_bytes, s_type, s_dyn} = rdata;
    assign raddr = scan_reg[AW-1:0];
    assign q_ready = (state_reg == bfi_pkg::ST_IDLE);
    assign accept = q_valid && q_ready;
    assign m_valid = outv_reg;
    assign m_res = res_reg;
    // best slot read lands in the cycle after entering done
    assign fire = (state_reg == bfi_pkg::ST_DONE) && rdok_reg && (!outv_reg || m_ready);

    always_comb begin
        fit = (s_ek == it_reg.elem_kind) && (s_ms == it_reg.mem_space);
        if (s_bytes != '0 && it_reg.byte_size != '0) begin
            fit = fit && (s_bytes >= it_reg.byte_size);
        end else if (s_bytes == '0 && it_reg.byte_size == '0) begin
            fit = fit && (s_type == it_reg.type_ident)
                      && (s_dyn == it_reg.dyn_sizes_ident);
        end else begin
            fit = 1'b0;
        end
        w = s_bytes - it_reg.byte_size;
        take = rvalid_reg && !stop_reg && (s_last < it_reg.def_index) && fit
               && (!found_reg || w < bestw_reg);
        scan_end = (scan_reg >= count_reg) && !rvalid_reg;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bfi_pkg::ST_IDLE: if (accept) state_next = bfi_pkg::ST_SCAN;
            bfi_pkg::ST_SCAN: if (scan_end) state_next = bfi_pkg::ST_DONE;
            bfi_pkg::ST_DONE: if (fire) state_next = bfi_pkg::ST_IDLE;
            default: state_next = bfi_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        scan_next = scan_reg;
        if (accept) begin
            scan_next = '0;
        end else if (state_reg == bfi_pkg::ST_SCAN && scan_end) begin
            scan_next = CW'(best_reg);
        end else if (state_reg == bfi_pkg::ST_SCAN && scan_reg < count_reg) begin
            scan_next = scan_reg + CW'(1);
        end
    end

    always_comb begin
        we = 1'b0;
        waddr = best_reg;
        wdata = rdata;
        if (fire) begin
            if (found_reg) begin
                we = 1'b1;
                waddr = best_reg;
                wdata = {it_reg.last_use_index, s_ek, s_ms, s_bytes, s_type, s_dyn};
            end else if (count_reg < CW'(SLOT_COUNT)) begin
                we = 1'b1;
                waddr = count_reg[AW-1:0];
                wdata = {it_reg.last_use_index, it_reg.elem_kind, it_reg.mem_space,
                         it_reg.byte_size, it_reg.type_ident, it_reg.dyn_sizes_ident};
            end
        end
    end

    // in done state the ram read address rests on best slot, keep it there
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bfi_pkg::ST_IDLE;
            count_reg <= '0;
            outv_reg  <= 1'b0;
            rvalid_reg <= 1'b0;
            rdok_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            rvalid_reg <= (state_reg == bfi_pkg::ST_SCAN) && (scan_reg < count_reg)
                          && !accept;
            rdok_reg <= (state_reg == bfi_pkg::ST_DONE);
            if (fire) begin
                outv_reg <= 1'b1;
                if (!found_reg && count_reg < CW'(SLOT_COUNT)) begin
                    count_reg <= count_reg + CW'(1);
                end
            end else if (outv_reg && m_ready) begin
                outv_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        scan_reg <= scan_next;
        rslot_reg <= raddr;
        if (accept) begin
            it_reg <= q_item;
            found_reg <= 1'b0;
            stop_reg <= 1'b0;
            bestw_reg <= '0;
            best_reg <= '0;
            bestcast_reg <= 1'b0;
        end else if (take) begin
            found_reg <= 1'b1;
            best_reg <= rslot_reg;
            bestw_reg <= w;
            bestcast_reg <= (s_type != it_reg.type_ident);
            stop_reg <= (w == '0);
        end
        if (fire) begin
            res_reg.table_full <= !found_reg && (count_reg >= CW'(SLOT_COUNT));
            res_reg.reused <= found_reg;
            res_reg.cast_needed <= found_reg && bestcast_reg;
            res_reg.waste <= found_reg ? bestw_reg : '0;
            if (found_reg) begin
                res_reg.slot_index <= 5'(best_reg);
            end else if (count_reg < CW'(SLOT_COUNT)) begin
                res_reg.slot_index <= 5'(count_reg);
            end else begin
                res_reg.slot_index <= '0;
            end
        end
    end

    `BFI_ASSERT_IMPL(a_count_max, aclk, aresetn, 1'b1, count_reg <= CW'(SLOT_COUNT))
    `BFI_ASSERT_IMPL(a_full_excl, aclk, aresetn, outv_reg,
        !(res_reg.table_full && res_reg.reused))
    `BFI_ASSERT_NEXT(a_fire_out, aclk, aresetn, fire, outv_reg)
endmodule

/* sv/best_fit_interval_slot_reuse_top.sv */
// Best-fit slot reuse: a two-beat input queue feeds a scanner that reads one slot
// per cycle from a single ram port; it takes no new item until the last has gone
// through its scan and done states, done fetching and writing back the chosen slot;
// a held result stalls the write-back. A zero-waste hit stops updating but the scan
// runs on.
// depends on bfi_pkg, bfi_front, bfi_back
module best_fit_interval_slot_reuse_top #(
    parameter int SLOT_COUNT = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // def_index, last_use_index, elem_kind, mem_space, byte_size, type_ident,
    // dyn_sizes_ident, zero pad
    input  logic [119:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // slot_index, reused, cast_needed, waste, table_full
    output logic [47:0]  m_tdata
);
    bfi_pkg::item_t   in_item, q_item;
    bfi_pkg::result_t res;
    logic q_valid, q_ready;

    assign in_item = s_tdata[115:0];
    assign m_tdata = res;

    bfi_front u_front (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_tvalid), .in_ready(s_tready),
        .in_item(in_item), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    bfi_back #(.SLOT_COUNT(SLOT_COUNT)) u_back (
        .aclk(aclk), .aresetn(aresetn), .q_valid(q_valid), .q_ready(q_ready),
        .q_item(q_item), .m_valid(m_tvalid), .m_ready(m_tready), .m_res(res)
    );
endmodule

/* bench/tb_best_fit_interval_slot_reuse_top.sv */
// testbench for the best-fit slot reuse block: streams buffer intervals in, checks slot results
// against a behavioural predictor held in a small scoreboard class
// depends on bfi_pkg and best_fit_interval_slot_reuse_top
module tb_best_fit_interval_slot_reuse_top;
    localparam int NSLOT = 32;
    localparam int WATCHDOG = 20000;

    class slot_scoreboard;
        bit          valid [NSLOT];
        bit [15:0]   last_use [NSLOT];
        bit [7:0]    ek [NSLOT];
        bit [3:0]    ms [NSLOT];
        bit [39:0]   bytes [NSLOT];
        bit [15:0]   ty [NSLOT];
        bit [15:0]   dyn [NSLOT];
        int          used;
        bfi_pkg::result_t pending [$];
        int          errors;

        function void note_item(bfi_pkg::item_t it);
            bit found;
            int best;
            bit [39:0] best_w, w;
            bit ok;
            bfi_pkg::result_t r;
            found = 0;
            best = 0;
            best_w = 0;
            r = '0;
            for (int s = 0; s < used; s++) begin
                if (!valid[s] || last_use[s] >= it.def_index) continue;
                ok = 0;
                if (ek[s] == it.elem_kind && ms[s] == it.mem_space) begin
                    if (bytes[s] != 0 && it.byte_size != 0)
                        ok = bytes[s] >= it.byte_size;
                    else if (bytes[s] == 0 && it.byte_size == 0)
                        ok = ty[s] == it.type_ident && dyn[s] == it.dyn_sizes_ident;
                end
                if (!ok) continue;
                w = bytes[s] - it.byte_size;
                if (!found || w < best_w) begin
                    found = 1;
                    best = s;
                    best_w = w;
                    if (w == 0) break;
                end
            end
            if (found) begin
                r.slot_index = best[4:0];
                r.reused = 1;
                r.cast_needed = ty[best] != it.type_ident;
                r.waste = best_w;
                last_use[best] = it.last_use_index;
            end else if (used < NSLOT) begin
                valid[used] = 1;
                last_use[used] = it.last_use_index;
                ek[used] = it.elem_kind;
                ms[used] = it.mem_space;
                bytes[used] = it.byte_size;
                ty[used] = it.type_ident;
                dyn[used] = it.dyn_sizes_ident;
                r.slot_index = used[4:0];
                used++;
            end else begin
                r.table_full = 1;
            end
            pending = {pending, r};
        endfunction

        function void check_result(bfi_pkg::result_t got);
            bfi_pkg::result_t e;
            if (pending.size() == 0) begin
                $error("result beat with nothing expected: %h", got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.slot_index != e.slot_index) begin
                $error("slot_index expected %0d actual %0d", e.slot_index, got.slot_index);
                errors++;
            end
            if (got.reused != e.reused) begin
                $error("reused expected %0d actual %0d", e.reused, got.reused);
                errors++;
            end
            if (got.cast_needed != e.cast_needed) begin
                $error("cast_needed expected %0d actual %0d", e.cast_needed, got.cast_needed);
                errors++;
            end
            if (got.waste != e.waste) begin
                $error("waste expected %0d actual %0d", e.waste, got.waste);
                errors++;
            end
            if (got.table_full != e.table_full) begin
                $error("table_full expected %0d actual %0d", e.table_full, got.table_full);
                errors++;
            end
        endfunction
    endclass

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [119:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [47:0]  m_tdata;

    best_fit_interval_slot_reuse_top #(.SLOT_COUNT(NSLOT)) i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    slot_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_off = 0;
    int quiet = 0;
    int pos = 0;

    // accept and check on the rising edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_item(bfi_pkg::item_t'(s_tdata[115:0]));
            if (m_tvalid && m_tready) sb.check_result(bfi_pkg::result_t'(m_tdata));
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
            if (quiet >= WATCHDOG) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // receiver ready, with random stall and a long hold-off counted here
    always @(negedge aclk) begin
        if (hold_off > 0) begin
            hold_off--;
            m_tready <= 0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // valid stays up on return so back-to-back beats need no gap
    task automatic send_item(bfi_pkg::item_t it);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 0;
            @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {4'd0, it};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic bfi_pkg::item_t rand_item(bit allow_random_pos);
        bfi_pkg::item_t it;
        int kind;
        kind = int'($urandom_range(9));
        it.def_index = pos[15:0];
        it.last_use_index = 16'(pos + int'($urandom_range(12)));
        it.elem_kind = 8'($urandom_range(2));
        it.mem_space = 4'($urandom_range(1));
        it.type_ident = 16'($urandom_range(3));
        it.dyn_sizes_ident = 16'($urandom_range(2));
        if (kind < 3) it.byte_size = 0;
        else if (kind < 8) it.byte_size = 40'($urandom_range(1, 64) * 16);
        else it.byte_size = 40'({$urandom(), $urandom()});
        if (kind == 9 && allow_random_pos) begin
            it.def_index = 16'($urandom());
            it.last_use_index = 16'($urandom());
            it.elem_kind = 8'($urandom());
            it.mem_space = 4'($urandom());
            it.type_ident = 16'($urandom());
            it.dyn_sizes_ident = 16'($urandom());
        end
        return it;
    endfunction

    task automatic drain();
        s_tvalid <= 0;
        while (sb.pending.size() > 0) @(negedge aclk);
        repeat (NSLOT + 10) @(negedge aclk);
    endtask

    initial begin
        bfi_pkg::item_t it;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // directed: extremes, new slots, static and dynamic reuse, cast, full table
        it = '0;
        it.def_index = 16'd0; it.last_use_index = 16'd1; it.byte_size = 40'd100;
        send_item(it);
        it.def_index = 16'd2; it.last_use_index = 16'd3; it.byte_size = 40'd100;
        it.type_ident = 16'd7;
        send_item(it);
        it.def_index = 16'd4; it.last_use_index = 16'd5; it.byte_size = 40'd40;
        send_item(it);
        it = '0;
        it.def_index = 16'd6; it.last_use_index = 16'd8; it.type_ident = 16'd9;
        it.dyn_sizes_ident = 16'd3;
        send_item(it);
        it.def_index = 16'd9; it.last_use_index = 16'd10;
        send_item(it);
        it.dyn_sizes_ident = 16'd4; it.def_index = 16'd11;
        send_item(it);
        it = '1;
        it.def_index = 16'hFFFF; it.last_use_index = 16'hFFFF;
        send_item(it);
        it.byte_size = 40'hFF_FFFF_FFFE;
        send_item(it);
        for (int i = 0; i < 30; i++) begin
            it = '0;
            it.elem_kind = 8'd200; it.mem_space = 4'd15; it.byte_size = 40'd8;
            it.def_index = 16'd0; it.last_use_index = 16'hFFFF;
            send_item(it);
        end
        drain();

        // random phases on a fresh table per phase would need reset; keep state and
        // let program position advance so slots recycle
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 49; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 49; end
                3: begin send_idle_pct = 37; recv_stall_pct = 37; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            if (ph == 4) hold_off = 400;
            for (int i = 0; i < 360; i++) begin
                pos = pos + int'($urandom_range(1, 8));
                send_item(rand_item(1));
            end
        end
        drain();
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
